>>> sv/pds_pkg.sv
package pds_pkg;

   localparam int RATE_W     = 20;
   localparam int MULT_W     = 9;
   localparam int POST_W     = 3;
   localparam int DIV_W      = 9;
   localparam int HALF_W     = DIV_W - 1;
   localparam int MCLK_SHIFT = 8;
   localparam int NUM_W      = 29;
   localparam int PT_W       = RATE_W + POST_W;
   localparam int DIVR_W     = PT_W + MCLK_SHIFT;
   localparam int CAND_W     = NUM_W + 1;
   localparam int CNT_W      = $clog2(NUM_W);

   localparam logic [MULT_W-1:0] MULT_MIN = 9'd192;
   localparam logic [MULT_W-1:0] MULT_MAX = 9'd432;
   localparam logic [POST_W-1:0] POST_MIN = 3'd2;
   localparam logic [POST_W-1:0] POST_MAX = 3'd7;
   localparam logic [DIV_W-1:0]  DIV_MIN  = 9'd4;
   localparam logic [DIV_W-1:0]  DIV_MAX  = 9'd511;
   localparam logic [RATE_W-1:0] REF_HZ   = 20'd1000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PAIR,
      ST_DIV0,
      ST_WAIT0,
      ST_CAND,
      ST_DIV1,
      ST_WAIT1,
      ST_CMP,
      ST_STEP,
      ST_RESP
   } pds_state_type;

   typedef enum logic {
      DIV_SEL_D0,
      DIV_SEL_RATE
   } pds_div_sel_type;

   typedef struct packed {
      logic            load;
      logic            pair;
      logic            div_start;
      pds_div_sel_type div_sel;
      logic            keep_d0;
      logic            cand;
      logic            compare;
      logic            next_k;
      logic            next_pair;
   } pds_cmd_type;

   typedef struct packed {
      logic target_zero;
      logic div_busy;
      logic div_done;
      logic d_ok;
      logic exact;
      logic k_one;
      logic pair_last;
   } pds_status_type;

endpackage

>>> sv/pds_divider.sv
module pds_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pds_pkg::NUM_W-1:0]  dividend,
   input  logic [pds_pkg::DIVR_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [pds_pkg::NUM_W-1:0]  quotient
);
   import pds_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [DIVR_W-1:0]   dsr_ff, dsr_in;
   logic [DIVR_W:0]     trial;
   logic [DIVR_W:0]     diff;
   logic                ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/pds_datapath.sv
module pds_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  pds_pkg::pds_cmd_type        cmd,
   output pds_pkg::pds_status_type     status,
   input  logic [pds_pkg::RATE_W-1:0]  target_rate,
   output logic [pds_pkg::MULT_W-1:0]  pll_mult,
   output logic [pds_pkg::POST_W-1:0]  pll_post_div,
   output logic [pds_pkg::HALF_W-1:0]  half_divider,
   output logic                        odd_bit,
   output logic [pds_pkg::RATE_W-1:0]  rate_error,
   output logic                        res_status
);
   import pds_pkg::*;

   logic [RATE_W-1:0] target_ff;
   logic [MULT_W-1:0] n_ff, n_in;
   logic [POST_W-1:0] r_ff, r_in;
   logic              k_ff, k_in;
   logic [NUM_W-1:0]  num_ff;
   logic [DIVR_W-1:0] div1_ff;
   logic [DIVR_W-1:0] div2_ff;
   logic [NUM_W-1:0]  d0_ff;
   logic [DIV_W-1:0]  d_ff;
   logic [MULT_W-1:0] best_n_ff;
   logic [POST_W-1:0] best_r_ff;
   logic [DIV_W-1:0]  best_d_ff;
   logic [RATE_W-1:0] best_err_ff;
   logic              found_ff, found_in;
   logic              exact_ff, exact_in;

   logic [PT_W-1:0]   rt_prod;
   logic [DIV_W+POST_W-1:0] rd_prod;
   logic [CAND_W-1:0] cand_d;
   logic [DIVR_W-1:0] div_divisor;
   logic              div_busy, div_done;
   logic [NUM_W-1:0]  quotient;
   logic [NUM_W-1:0]  diff;
   logic [RATE_W-1:0] err;
   logic              better;

   pds_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign div_divisor = (cmd.div_sel == DIV_SEL_RATE) ? div2_ff : div1_ff;

   assign rt_prod = PT_W'(r_ff) * PT_W'(target_ff);
   assign cand_d  = {1'b0, d0_ff} + CAND_W'(k_ff);
   assign rd_prod = (DIV_W+POST_W)'(r_ff) * (DIV_W+POST_W)'(cand_d[DIV_W-1:0]);

   assign diff = (quotient > NUM_W'(target_ff)) ? (quotient - NUM_W'(target_ff))
                                                : (NUM_W'(target_ff) - quotient);
   assign err    = diff[RATE_W-1:0];
   assign better = !found_ff || (err < best_err_ff);

   always_comb begin
      n_in     = n_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      found_in = found_ff;
      exact_in = exact_ff;
      if (cmd.load) begin
         n_in     = MULT_MIN;
         r_in     = POST_MIN;
         k_in     = 1'b0;
         found_in = 1'b0;
         exact_in = 1'b0;
      end else if (cmd.next_k) begin
         k_in = 1'b1;
      end else if (cmd.next_pair) begin
         k_in = 1'b0;
         if (r_ff == POST_MAX) begin
            r_in = POST_MIN;
            n_in = n_ff + 1'b1;
         end else begin
            r_in = r_ff + 1'b1;
         end
      end else if (cmd.compare && better) begin
         found_in = 1'b1;
         exact_in = (err == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= MULT_MIN;
         r_ff     <= POST_MIN;
         k_ff     <= 1'b0;
         found_ff <= 1'b0;
         exact_ff <= 1'b0;
      end else begin
         n_ff     <= n_in;
         r_ff     <= r_in;
         k_ff     <= k_in;
         found_ff <= found_in;
         exact_ff <= exact_in;
      end
      if (cmd.load) begin
         target_ff <= target_rate;
      end
      if (cmd.pair) begin
         num_ff  <= NUM_W'(n_ff) * NUM_W'(REF_HZ);
         div1_ff <= {rt_prod, {MCLK_SHIFT{1'b0}}};
      end
      if (cmd.keep_d0) begin
         d0_ff <= quotient;
      end
      if (cmd.cand) begin
         d_ff    <= cand_d[DIV_W-1:0];
         div2_ff <= DIVR_W'({rd_prod, {MCLK_SHIFT{1'b0}}});
      end
      if (cmd.compare && better) begin
         best_n_ff   <= n_ff;
         best_r_ff   <= r_ff;
         best_d_ff   <= d_ff;
         best_err_ff <= err;
      end
   end

   assign status.target_zero = (target_ff == '0);
   assign status.div_busy    = div_busy;
   assign status.div_done    = div_done;
   assign status.d_ok        = (cand_d >= CAND_W'(DIV_MIN)) && (cand_d <= CAND_W'(DIV_MAX));
   assign status.exact       = exact_ff;
   assign status.k_one       = k_ff;
   assign status.pair_last   = (n_ff == MULT_MAX) && (r_ff == POST_MAX);

   assign pll_mult     = found_ff ? best_n_ff : '0;
   assign pll_post_div = found_ff ? best_r_ff : '0;
   assign half_divider = found_ff ? best_d_ff[DIV_W-1:1] : '0;
   assign odd_bit      = found_ff ? best_d_ff[0] : 1'b0;
   assign rate_error   = found_ff ? best_err_ff : '0;
   assign res_status   = !found_ff;

`ifndef SYNTHESIS
   a_best_div_range: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_d_ff >= DIV_MIN))
      else $error("kept divider below range");
   a_best_pair_range: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_r_ff >= POST_MIN) && (best_n_ff >= MULT_MIN)
                   && (best_n_ff <= MULT_MAX))
      else $error("kept PLL setting out of range");
   a_exact_found: assert property (@(posedge clock) disable iff (reset)
      exact_ff |-> found_ff && (best_err_ff == '0))
      else $error("exact flag without zero-error candidate");
`endif

endmodule

>>> sv/pds_control.sv
module pds_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pds_pkg::pds_cmd_type    cmd,
   input  pds_pkg::pds_status_type status
);
   import pds_pkg::*;

   pds_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.target_zero ? ST_RESP : ST_PAIR;
         end
         ST_PAIR:  state_in = ST_DIV0;
         ST_DIV0:  state_in = ST_WAIT0;
         ST_WAIT0: begin
            if (status.div_done) state_in = ST_CAND;
         end
         ST_CAND: begin
            state_in = status.d_ok ? ST_DIV1 : ST_STEP;
         end
         ST_DIV1:  state_in = ST_WAIT1;
         ST_WAIT1: begin
            if (status.div_done) state_in = ST_CMP;
         end
         ST_CMP:   state_in = ST_STEP;
         ST_STEP: begin
            if (status.exact) begin
               state_in = ST_RESP;
            end else if (!status.k_one) begin
               state_in = ST_CAND;
            end else if (status.pair_last) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_PAIR;
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PAIR: begin
            cmd.pair = 1'b1;
         end
         ST_DIV0: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_D0;
         end
         ST_WAIT0: begin
            cmd.keep_d0 = status.div_done;
         end
         ST_CAND: begin
            cmd.cand = status.d_ok;
         end
         ST_DIV1: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_RATE;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
         end
         ST_STEP: begin
            if (!status.exact) begin
               if (!status.k_one) begin
                  cmd.next_k = 1'b1;
               end else if (!status.pair_last) begin
                  cmd.next_pair = 1'b1;
               end
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_valid_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while result pending");
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider restarted while busy");
   a_compare_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.compare |-> $past(status.div_done))
      else $error("compare without fresh quotient");
`endif

endmodule

>>> sv/pll_divider_search.sv
// channel  | valid / ready          | payload
// ---------+------------------------+-----------------------------------------------
// request  | req_valid / req_ready  | req_target_rate
// response | rsp_valid / rsp_ready  | rsp_pll_mult, rsp_pll_post_div, rsp_half_divider,
//          |                        | rsp_odd_bit, rsp_rate_error, rsp_status
//
// One item at a time: req_ready is high only while idle.
// Each (N, R) pair runs one division for the base divider d0, then one more for each
// in-range divider tried (d0 and d0 + 1), all on the shared 29-step restoring divider.
// A zero target goes from the check state straight to the response state;
// an exact match ends the search early.
// Synchronous active-high reset returns to idle; the result is held until rsp_ready.
module pll_divider_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pds_pkg::RATE_W-1:0]  req_target_rate,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pds_pkg::MULT_W-1:0]  rsp_pll_mult,
   output logic [pds_pkg::POST_W-1:0]  rsp_pll_post_div,
   output logic [pds_pkg::HALF_W-1:0]  rsp_half_divider,
   output logic                        rsp_odd_bit,
   output logic [pds_pkg::RATE_W-1:0]  rsp_rate_error,
   output logic                        rsp_status
);
   import pds_pkg::*;

   pds_cmd_type    cmd;
   pds_status_type status;

   pds_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pds_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .target_rate  (req_target_rate),
      .pll_mult     (rsp_pll_mult),
      .pll_post_div (rsp_pll_post_div),
      .half_divider (rsp_half_divider),
      .odd_bit      (rsp_odd_bit),
      .rate_error   (rsp_rate_error),
      .res_status   (rsp_status)
   );

endmodule

>>> verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pds_pkg::*;

   typedef struct packed {
      logic [MULT_W-1:0] pll_mult;
      logic [POST_W-1:0] pll_post_div;
      logic [HALF_W-1:0] half_divider;
      logic              odd_bit;
      logic [RATE_W-1:0] rate_error;
      logic              status;
   } pll_setting_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [RATE_W-1:0] req_target_rate = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [MULT_W-1:0] rsp_pll_mult;
   logic [POST_W-1:0] rsp_pll_post_div;
   logic [HALF_W-1:0] rsp_half_divider;
   logic              rsp_odd_bit;
   logic [RATE_W-1:0] rsp_rate_error;
   logic              rsp_status;

   pll_setting_type expected_settings[$];
   pll_setting_type want_setting;
   int           mismatch_count = 0;
   int           burst_left = 0;
   logic [5:0]   stall_tick = '0;
   logic [7:0]   stall_mask = '1;
   int           audio_rates[11] = '{8000, 11025, 16000, 22050, 32000, 44100,
                                     48000, 88200, 96000, 176400, 192000};

   pll_divider_search u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_rate  (req_target_rate),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pll_mult     (rsp_pll_mult),
      .rsp_pll_post_div (rsp_pll_post_div),
      .rsp_half_divider (rsp_half_divider),
      .rsp_odd_bit      (rsp_odd_bit),
      .rsp_rate_error   (rsp_rate_error),
      .rsp_status       (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // closest PLL setting; first strictly better candidate wins, exact match stops
   function automatic pll_setting_type search_pll_setting(input logic [RATE_W-1:0] target);
      pll_setting_type   best;
      logic              found;
      logic              exact;
      longint unsigned   numer;
      longint unsigned   span;
      longint unsigned   d0;
      longint unsigned   div;
      longint unsigned   rate;
      longint unsigned   err;
      longint unsigned   best_err;
      int                n;
      int                r;
      int                k;
      best = '0;
      found = 1'b0;
      exact = 1'b0;
      best_err = 0;
      if (target != '0) begin
         for (n = int'(MULT_MIN); n <= int'(MULT_MAX) && !exact; n++) begin
            for (r = int'(POST_MIN); r <= int'(POST_MAX) && !exact; r++) begin
               numer = longint'(n) * longint'(REF_HZ);
               span  = (longint'(r) * longint'(target)) << MCLK_SHIFT;
               d0    = numer / span;
               for (k = 0; k < 2 && !exact; k++) begin
                  div = d0 + longint'(k);
                  if (div >= longint'(DIV_MIN) && div <= longint'(DIV_MAX)) begin
                     rate = numer / ((longint'(r) * div) << MCLK_SHIFT);
                     err  = (rate > target) ? rate - target : target - rate;
                     if (!found || err < best_err) begin
                        found = 1'b1;
                        best_err = err;
                        best.pll_mult     = n[MULT_W-1:0];
                        best.pll_post_div = r[POST_W-1:0];
                        best.half_divider = div[HALF_W:1];
                        best.odd_bit      = div[0];
                        best.rate_error   = err[RATE_W-1:0];
                        if (err == 0) begin
                           exact = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end
      best.status = !found;
      return best;
   endfunction

   task automatic send_target(input logic [RATE_W-1:0] target);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_target_rate <= target;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_settings.push_back(search_pll_setting(target));
   endtask

   task automatic test_range_edges();
      send_target(20'd0);
      send_target(20'd1);
      send_target(20'd209);
      send_target(20'd210);
      send_target(20'd211);
      send_target(20'd281250);
      send_target(20'd281251);
      send_target(20'd349525);
      send_target(20'd699050);
      send_target(20'd1000000);
      send_target(20'hFFFFF);
   endtask

   task automatic test_audio_rates();
      foreach (audio_rates[i]) begin
         send_target(audio_rates[i][RATE_W-1:0]);
      end
   endtask

   task automatic test_random_targets(input int count);
      int pick;
      int target;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            target = $urandom_range(210, 281250);
         end else if (pick < 7) begin
            target = audio_rates[$urandom_range(0, 10)] + $urandom_range(0, 40) - 20;
         end else if (pick < 9) begin
            target = $urandom_range(0, 20'hFFFFF);
         end else begin
            target = $urandom_range(1, 300);
         end
         send_target(target[RATE_W-1:0]);
      end
   endtask

   // response side: check each item, stall on a rolling mask
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_tick <= '0;
         stall_mask <= '1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_settings.size() == 0) begin
               $error("unexpected result item");
               mismatch_count++;
            end else begin
               want_setting = expected_settings.pop_front();
               if (rsp_pll_mult !== want_setting.pll_mult) begin
                  $error("pll_mult: expected %0d, got %0d", want_setting.pll_mult,
                         rsp_pll_mult);
                  mismatch_count++;
               end
               if (rsp_pll_post_div !== want_setting.pll_post_div) begin
                  $error("pll_post_div: expected %0d, got %0d", want_setting.pll_post_div,
                         rsp_pll_post_div);
                  mismatch_count++;
               end
               if (rsp_half_divider !== want_setting.half_divider) begin
                  $error("half_divider: expected %0d, got %0d", want_setting.half_divider,
                         rsp_half_divider);
                  mismatch_count++;
               end
               if (rsp_odd_bit !== want_setting.odd_bit) begin
                  $error("odd_bit: expected %0d, got %0d", want_setting.odd_bit,
                         rsp_odd_bit);
                  mismatch_count++;
               end
               if (rsp_rate_error !== want_setting.rate_error) begin
                  $error("rate_error: expected %0d, got %0d", want_setting.rate_error,
                         rsp_rate_error);
                  mismatch_count++;
               end
               if (rsp_status !== want_setting.status) begin
                  $error("status: expected %0d, got %0d", want_setting.status,
                         rsp_status);
                  mismatch_count++;
               end
            end
         end
         stall_tick <= stall_tick + 6'd1;
         if (stall_tick == '1) begin
            stall_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
         end
         rsp_ready <= stall_mask[stall_tick[2:0]];
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_range_edges();
      test_audio_rates();
      test_random_targets(78);
      req_valid <= 1'b0;
      wait (expected_settings.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
